[rtl/core/pksv_pkg.sv]
// Package for the power key sequencer with supply voltage report.
// Holds the sizing constants, command and reply codes, state types and the
// command/status structs shared by the controller and the datapath.
package pksv_pkg;

	localparam int AVG_LOG2 = 3;
	localparam int ADC_BITS = 10;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 12;
	localparam int BANDGAP_W = 12;
	localparam int ON_HOLD_W = 8;
	localparam int HOLD_W = 12;
	localparam int DELAY_W = 10;

	localparam int DISCARD_N = 2;
	localparam int AVG_N = 1 << AVG_LOG2;
	localparam int FIRST_KEPT = DISCARD_N + 1;
	localparam int LAST_IDX = DISCARD_N + AVG_N;
	localparam int IDX_W = $clog2(LAST_IDX + 1);
	localparam int SUM_W = ADC_BITS + AVG_LOG2;

	localparam int NUM_W = BANDGAP_W + ADC_BITS;
	localparam int DEN_W = ADC_BITS;
	localparam int DIV_CNT_W = $clog2(NUM_W);
	localparam int VCC_W = 16;

	localparam logic [HOLD_W-1:0] HOLD_MAX = {HOLD_W{1'b1}};

	localparam logic [BANDGAP_W-1:0] BANDGAP_RST = 12'd1190;
	localparam logic [ON_HOLD_W-1:0] ON_HOLD_RST = 8'd180;
	localparam logic [HOLD_W-1:0] OFF_HOLD_RST = 12'd1900;
	localparam logic [DELAY_W-1:0] OFF_DELAY_RST = 10'd600;

	localparam logic [CFG_IDX_W-1:0] REG_BANDGAP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ON_HOLD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OFF_HOLD = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OFF_DELAY = 2'd3;

	localparam logic [1:0] CMD_TICK = 2'd0;
	localparam logic [1:0] CMD_RX = 2'd1;
	localparam logic [1:0] CMD_SAMPLE = 2'd2;

	localparam logic [7:0] BYTE_MEASURE = 8'h58;
	localparam logic [7:0] BYTE_CHARGE = 8'h59;
	localparam logic [7:0] BYTE_SHUTDOWN = 8'h6a;
	localparam logic [7:0] REPLY_CHARGING = 8'h01;
	localparam logic [7:0] REPLY_IDLE = 8'h00;

	typedef enum logic [1:0] {
		MODE_OFF,
		MODE_ON,
		MODE_PENDING
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_HI,
		ST_LO
	} ctrl_state_t;

	typedef struct packed {
		logic take;
		logic load_one;
		logic div_start;
		logic load_hi;
		logic load_lo;
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_free;
		logic fin;
		logic div_busy;
	} dp_status_t;

endpackage

[rtl/core/pksv_if.sv]
// Channel interfaces for the power key sequencer: input items, result items
// and configuration writes. Depends on pksv_pkg for field widths.
interface pksv_req_if;
	logic valid;
	logic ready;
	logic [1:0] command;
	logic key_pressed;
	logic charge_pin_high;
	logic [7:0] rx_byte;
	logic [pksv_pkg::ADC_BITS-1:0] adc_sample;

	modport source (output valid, command, key_pressed, charge_pin_high, rx_byte,
		adc_sample, input ready);
	modport sink (input valid, command, key_pressed, charge_pin_high, rx_byte,
		adc_sample, output ready);
endinterface

interface pksv_rsp_if;
	logic valid;
	logic ready;
	logic power_enable;
	logic tx_valid;
	logic [7:0] tx_byte;
	logic sample_wanted;
	logic last;

	modport source (output valid, power_enable, tx_valid, tx_byte, sample_wanted, last,
		input ready);
	modport sink (input valid, power_enable, tx_valid, tx_byte, sample_wanted, last,
		output ready);
endinterface

interface pksv_cfg_if;
	logic valid;
	logic ready;
	logic [pksv_pkg::CFG_IDX_W-1:0] index;
	logic [pksv_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/power_key_sequencer_with_vcc_report_unit.sv]
// Top level of the power key sequencer with supply voltage report.
// Ticks, UART bytes and samples give one result in the cycle after acceptance;
// a new transaction is taken every cycle the result register is free.
// The sample that ends a measurement starts the divider; its two results, high byte
// then low, follow once it is done; the next transaction is taken after the low byte.
// Asynchronous active-low reset: power mode off, counters zero, registers at defaults.
module power_key_sequencer_with_vcc_report_unit (
	input  logic        clk,
	input  logic        arst_n,
	pksv_req_if.sink    req,
	pksv_rsp_if.source  rsp,
	pksv_cfg_if.sink    cfg
);

	pksv_pkg::ctrl_cmd_t  cmd;
	pksv_pkg::dp_status_t status;

	pksv_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.status   (status),
		.cmd      (cmd)
	);

	pksv_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.command         (req.command),
		.key_pressed     (req.key_pressed),
		.charge_pin_high (req.charge_pin_high),
		.rx_byte         (req.rx_byte),
		.adc_sample      (req.adc_sample),
		.cfg_valid       (cfg.valid),
		.cfg_ready       (cfg.ready),
		.cfg_index       (cfg.index),
		.cfg_data        (cfg.data),
		.out_valid       (rsp.valid),
		.out_ready       (rsp.ready),
		.power_enable    (rsp.power_enable),
		.tx_valid        (rsp.tx_valid),
		.tx_byte         (rsp.tx_byte),
		.sample_wanted   (rsp.sample_wanted),
		.last            (rsp.last)
	);

endmodule

[rtl/core/pksv_div.sv]
// Restoring divider, one quotient bit per cycle, for the voltage report.
// Depends on pksv_pkg for the numerator and divisor widths.
module pksv_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [pksv_pkg::NUM_W-1:0]    num,
	input  logic [pksv_pkg::DEN_W-1:0]    den,
	output logic                          busy,
	output logic [pksv_pkg::NUM_W-1:0]    quo
);

	logic                            busy_q;
	logic [pksv_pkg::DIV_CNT_W-1:0]  cnt_q;
	logic [pksv_pkg::DEN_W-1:0]      den_q;
	logic [pksv_pkg::DEN_W-1:0]      rem_q;
	logic [pksv_pkg::NUM_W-1:0]      quo_q;
	logic [pksv_pkg::DEN_W:0]        trial;
	logic                            qbit;
	logic [pksv_pkg::DEN_W-1:0]      rem_d;

	always_comb begin
		trial = {rem_q, quo_q[pksv_pkg::NUM_W-1]};
		qbit = (trial >= {1'b0, den_q});
		if (qbit) begin
			rem_d = pksv_pkg::DEN_W'(trial - {1'b0, den_q});
		end else begin
			rem_d = trial[pksv_pkg::DEN_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= '0;
		end else if (busy_q) begin
			if (cnt_q == pksv_pkg::DIV_CNT_W'(pksv_pkg::NUM_W - 1)) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			rem_q <= '0;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= rem_d;
			quo_q <= {quo_q[pksv_pkg::NUM_W-2:0], qbit};
		end
	end

	assign busy = busy_q;
	assign quo = quo_q;

endmodule

[rtl/core/pksv_ctrl.sv]
// Controller state machine: accepts items, runs the divider for a finished
// measurement and sequences the two reply bytes. Depends on pksv_pkg.
module pksv_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  pksv_pkg::dp_status_t    status,
	output pksv_pkg::ctrl_cmd_t     cmd
);

	pksv_pkg::ctrl_state_t state_q;
	pksv_pkg::ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pksv_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			pksv_pkg::ST_IDLE: begin
				in_ready = status.out_free;
				if (in_valid && status.out_free) begin
					cmd.take = 1'b1;
					if (status.fin) begin
						cmd.div_start = 1'b1;
						state_d = pksv_pkg::ST_DIV;
					end else begin
						cmd.load_one = 1'b1;
					end
				end
			end
			pksv_pkg::ST_DIV: begin
				if (!status.div_busy) begin
					state_d = pksv_pkg::ST_HI;
				end
			end
			pksv_pkg::ST_HI: begin
				if (status.out_free) begin
					cmd.load_hi = 1'b1;
					state_d = pksv_pkg::ST_LO;
				end
			end
			pksv_pkg::ST_LO: begin
				if (status.out_free) begin
					cmd.load_lo = 1'b1;
					state_d = pksv_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pksv_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

[rtl/core/pksv_dp.sv]
// Datapath: configuration registers, power and key state, sample averaging,
// divider and the result register. Depends on pksv_pkg and pksv_div.
module pksv_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  pksv_pkg::ctrl_cmd_t               cmd,
	output pksv_pkg::dp_status_t              status,
	input  logic [1:0]                        command,
	input  logic                              key_pressed,
	input  logic                              charge_pin_high,
	input  logic [7:0]                        rx_byte,
	input  logic [pksv_pkg::ADC_BITS-1:0]     adc_sample,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [pksv_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pksv_pkg::CFG_DATA_W-1:0]   cfg_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              power_enable,
	output logic                              tx_valid,
	output logic [7:0]                        tx_byte,
	output logic                              sample_wanted,
	output logic                              last
);

	logic [pksv_pkg::BANDGAP_W-1:0] bandgap_q;
	logic [pksv_pkg::ON_HOLD_W-1:0] on_hold_q;
	logic [pksv_pkg::HOLD_W-1:0]    off_hold_q;
	logic [pksv_pkg::DELAY_W-1:0]   off_delay_q;

	pksv_pkg::mode_t                mode_q;
	pksv_pkg::mode_t                mode_d;
	logic [pksv_pkg::HOLD_W-1:0]    hold_q;
	logic [pksv_pkg::HOLD_W-1:0]    hold_d;
	logic [pksv_pkg::HOLD_W-1:0]    hold_inc;
	logic [pksv_pkg::DELAY_W-1:0]   sd_q;
	logic [pksv_pkg::DELAY_W-1:0]   sd_d;
	logic [pksv_pkg::IDX_W-1:0]     idx_q;
	logic [pksv_pkg::IDX_W-1:0]     idx_d;
	logic [pksv_pkg::SUM_W-1:0]     sum_q;
	logic [pksv_pkg::SUM_W-1:0]     sum_d;
	logic [pksv_pkg::SUM_W-1:0]     sum_acc;
	logic                           reply_v;
	logic [7:0]                     reply_b;
	logic                           fin;

	logic                           div_busy;
	logic [pksv_pkg::NUM_W-1:0]     div_quo;
	logic [pksv_pkg::VCC_W-1:0]     vcc;

	logic                           out_valid_q;
	logic                           power_q;
	logic                           tx_valid_q;
	logic [7:0]                     tx_byte_q;
	logic                           wanted_q;
	logic                           last_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bandgap_q <= pksv_pkg::BANDGAP_RST;
			on_hold_q <= pksv_pkg::ON_HOLD_RST;
			off_hold_q <= pksv_pkg::OFF_HOLD_RST;
			off_delay_q <= pksv_pkg::OFF_DELAY_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				pksv_pkg::REG_BANDGAP: bandgap_q <= cfg_data[pksv_pkg::BANDGAP_W-1:0];
				pksv_pkg::REG_ON_HOLD: on_hold_q <= cfg_data[pksv_pkg::ON_HOLD_W-1:0];
				pksv_pkg::REG_OFF_HOLD: off_hold_q <= cfg_data[pksv_pkg::HOLD_W-1:0];
				pksv_pkg::REG_OFF_DELAY: off_delay_q <= cfg_data[pksv_pkg::DELAY_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign sum_acc = sum_q + pksv_pkg::SUM_W'(adc_sample);

	always_comb begin
		mode_d = mode_q;
		hold_d = hold_q;
		sd_d = sd_q;
		idx_d = idx_q;
		sum_d = sum_q;
		reply_v = 1'b0;
		reply_b = pksv_pkg::REPLY_IDLE;
		fin = 1'b0;
		if (!key_pressed) begin
			hold_inc = '0;
		end else if (hold_q == pksv_pkg::HOLD_MAX) begin
			hold_inc = hold_q;
		end else begin
			hold_inc = hold_q + 1'b1;
		end
		unique case (command)
			pksv_pkg::CMD_TICK: begin
				hold_d = hold_inc;
				if (mode_q == pksv_pkg::MODE_OFF) begin
					if (key_pressed && (hold_inc >= pksv_pkg::HOLD_W'(on_hold_q))) begin
						mode_d = pksv_pkg::MODE_ON;
						hold_d = '0;
					end
				end else if ((key_pressed && (hold_inc >= off_hold_q)) ||
					((mode_q == pksv_pkg::MODE_PENDING) && (sd_q == '0))) begin
					mode_d = pksv_pkg::MODE_OFF;
					hold_d = '0;
					sd_d = '0;
					idx_d = '0;
					sum_d = '0;
				end else if (mode_q == pksv_pkg::MODE_PENDING) begin
					sd_d = sd_q - 1'b1;
				end
			end
			pksv_pkg::CMD_RX: begin
				if (mode_q == pksv_pkg::MODE_ON) begin
					priority if (rx_byte == pksv_pkg::BYTE_SHUTDOWN) begin
						mode_d = pksv_pkg::MODE_PENDING;
						sd_d = off_delay_q;
					end else if (rx_byte == pksv_pkg::BYTE_CHARGE) begin
						reply_v = 1'b1;
						reply_b = charge_pin_high ? pksv_pkg::REPLY_IDLE
							: pksv_pkg::REPLY_CHARGING;
					end else if (rx_byte == pksv_pkg::BYTE_MEASURE) begin
						if (idx_q == '0) begin
							idx_d = pksv_pkg::IDX_W'(1);
							sum_d = '0;
						end
					end else begin
					end
				end
			end
			pksv_pkg::CMD_SAMPLE: begin
				if (idx_q != '0) begin
					if (idx_q >= pksv_pkg::IDX_W'(pksv_pkg::FIRST_KEPT)) begin
						sum_d = sum_acc;
					end
					if (idx_q == pksv_pkg::IDX_W'(pksv_pkg::LAST_IDX)) begin
						fin = 1'b1;
						idx_d = '0;
						sum_d = '0;
					end else begin
						idx_d = idx_q + 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= pksv_pkg::MODE_OFF;
			hold_q <= '0;
			sd_q <= '0;
			idx_q <= '0;
			sum_q <= '0;
		end else if (cmd.take) begin
			mode_q <= mode_d;
			hold_q <= hold_d;
			sd_q <= sd_d;
			idx_q <= idx_d;
			sum_q <= sum_d;
		end
	end

	pksv_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    ({bandgap_q, {pksv_pkg::ADC_BITS{1'b0}}}),
		.den    (sum_acc[pksv_pkg::SUM_W-1:pksv_pkg::AVG_LOG2]),
		.busy   (div_busy),
		.quo    (div_quo)
	);

	assign vcc = (div_quo[pksv_pkg::NUM_W-1:pksv_pkg::VCC_W] != '0) ? {pksv_pkg::VCC_W{1'b1}}
		: div_quo[pksv_pkg::VCC_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_one || cmd.load_hi || cmd.load_lo) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_one) begin
			power_q <= (mode_d != pksv_pkg::MODE_OFF);
			tx_valid_q <= reply_v;
			tx_byte_q <= reply_b;
			wanted_q <= (idx_d != '0);
			last_q <= 1'b1;
		end else if (cmd.load_hi || cmd.load_lo) begin
			power_q <= (mode_q != pksv_pkg::MODE_OFF);
			tx_valid_q <= 1'b1;
			tx_byte_q <= cmd.load_hi ? vcc[15:8] : vcc[7:0];
			wanted_q <= (idx_q != '0);
			last_q <= cmd.load_lo;
		end
	end

	assign status.out_free = !out_valid_q || out_ready;
	assign status.fin = fin;
	assign status.div_busy = div_busy;

	assign out_valid = out_valid_q;
	assign power_enable = power_q;
	assign tx_valid = tx_valid_q;
	assign tx_byte = tx_byte_q;
	assign sample_wanted = wanted_q;
	assign last = last_q;

endmodule
